// File: sv/lcc_pkg.sv
package lcc_pkg;

  localparam int MAP_SIZE  = 1024;
  localparam int ROW_W     = 16;
  localparam int BIT_W     = $clog2(ROW_W);
  localparam int ROWS      = (MAP_SIZE + ROW_W - 1) / ROW_W;
  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  // counter holds 1 .. MAP_SIZE+1
  localparam int CNT_W     = $clog2(MAP_SIZE + 2);
  localparam int RANGE_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int CMD_W     = 2;
  localparam int IN_DATA_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] NEWLINE     = 8'd10;
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd9;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE      = 2'd0,
    KIND_RANGE_OK  = 2'd1,
    KIND_RANGE_BAD = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUT_MODE  = 1'd0,
    REG_DELIMITER = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    MAP_IDLE,
    MAP_READ,
    MAP_WRITE,
    MAP_REFRESH
  } map_state_e;

  // request from the line logic to the selection map
  typedef struct packed {
    logic             clear;
    logic             mark;
    logic [CNT_W-1:0] first_idx;
    logic [CNT_W-1:0] last_idx;
  } map_req_t;

  // selection of the current position and of the one after it
  typedef struct packed {
    logic sel_cur;
    logic sel_next;
  } map_look_t;

  function automatic logic [ROW_IDX_W-1:0] row_of(input logic [CNT_W-1:0] idx);
    logic [CNT_W-1:0] r;
    r = idx >> BIT_W;
    if (r > CNT_W'(ROWS - 1)) begin
      row_of = ROW_IDX_W'(ROWS - 1);
    end else begin
      row_of = r[ROW_IDX_W-1:0];
    end
  endfunction

endpackage

// File: sv/line_field_char_cutter.sv
// Cuts fields or character positions out of each line of a byte stream, like
// the cut utility. Software clears the selection map, marks ranges (first and
// last position, 1 to 1024) and then streams bytes; each accepted item gives
// at most one result. Data bytes, map clears and end-of-stream items are taken
// one per cycle while the output register is free and the map is not busy,
// with their results going to the output register. A mark item returns its
// accept/reject status at once, but a good range then keeps the input stalled
// while each 16-position map row it spans goes through a read-modify-write on
// the map memory, and then for a refresh step. Clearing the map only resets
// the valid flop of each row, so no clearing pass runs after reset.
module line_field_char_cutter import lcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // range_first[11:0], range_last[23:12], data_byte[31:24]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_byte[7:0]
  output logic [BYTE_W-1:0]     m_axis_tdata,
  // out_kind[1:0]
  output logic [KIND_W-1:0]     m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [BYTE_W-1:0]     cfg_data_i
);

  logic              cut_mode_q;
  logic [BYTE_W-1:0] delim_q;

  logic [CNT_W-1:0]  count_q, count_d, count_inc;
  logic              ne_q, ne_d, ne_tmp;
  logic              open_q, open_d;

  logic              out_valid_q, out_free, in_acc;
  kind_e             out_kind_q, res_kind;
  logic [BYTE_W-1:0] out_byte_q, res_byte;
  logic              res_valid;

  map_req_t          map_req;
  map_look_t         look;
  logic              map_busy;
  logic [CNT_W-1:0]  look_idx;

  cmd_e               cmd;
  logic [RANGE_W-1:0] range_first, range_last, first_m1, last_m1;
  logic [BYTE_W-1:0]  data_byte;
  logic               range_bad;

  assign cmd         = cmd_e'(s_axis_tuser);
  assign range_first = s_axis_tdata[RANGE_W-1:0];
  assign range_last  = s_axis_tdata[2*RANGE_W-1:RANGE_W];
  assign data_byte   = s_axis_tdata[2*RANGE_W+BYTE_W-1:2*RANGE_W];
  assign first_m1    = range_first - 1'b1;
  assign last_m1     = range_last - 1'b1;
  assign range_bad   = (range_first == '0) || (range_last > RANGE_W'(MAP_SIZE))
                       || (range_first > range_last);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = out_free && !map_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // the counter stops one past the map, where nothing is selected
  assign count_inc = (count_q <= CNT_W'(MAP_SIZE)) ? count_q + 1'b1 : count_q;

  always_comb begin
    count_d   = count_q;
    ne_d      = ne_q;
    open_d    = open_q;
    ne_tmp    = ne_q;
    res_valid = 1'b0;
    res_kind  = KIND_BYTE;
    res_byte  = '0;
    map_req   = '0;
    if (in_acc) begin
      case (cmd)
        CMD_CLEAR: begin
          map_req.clear = 1'b1;
        end
        CMD_MARK: begin
          res_valid = 1'b1;
          if (range_bad) begin
            res_kind = KIND_RANGE_BAD;
          end else begin
            res_kind          = KIND_RANGE_OK;
            map_req.mark      = 1'b1;
            map_req.first_idx = CNT_W'(first_m1);
            map_req.last_idx  = CNT_W'(last_m1);
          end
        end
        CMD_END: begin
          count_d = CNT_W'(1);
          ne_d    = 1'b1;
          open_d  = 1'b0;
          if (open_q && !cut_mode_q && (look.sel_cur || !ne_q)) begin
            res_valid = 1'b1;
            res_byte  = NEWLINE;
          end
        end
        CMD_DATA: begin
          if (data_byte == NEWLINE) begin
            count_d   = CNT_W'(1);
            ne_d      = 1'b1;
            open_d    = 1'b0;
            res_valid = 1'b1;
            res_byte  = NEWLINE;
          end else begin
            open_d = 1'b1;
            if (cut_mode_q) begin
              count_d   = count_inc;
              res_valid = look.sel_cur;
              res_byte  = data_byte;
            end else begin
              // entering a selected field counts as output, even if empty
              if (look.sel_cur) ne_tmp = 1'b0;
              ne_d = ne_tmp;
              if (data_byte == delim_q) begin
                count_d = count_inc;
                if (look.sel_next) begin
                  ne_d      = 1'b0;
                  res_valid = !ne_tmp;
                  res_byte  = delim_q;
                end
              end else begin
                res_valid = look.sel_cur;
                res_byte  = data_byte;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign look_idx = count_d - 1'b1;

  lcc_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .map_req_i  (map_req),
    .look_idx_i (look_idx),
    .look_o     (look),
    .busy_o     (map_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_mode_q  <= 1'b0;
      delim_q     <= DELIM_RESET;
      count_q     <= CNT_W'(1);
      ne_q        <= 1'b1;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_CUT_MODE:  cut_mode_q <= cfg_data_i[0];
          REG_DELIMITER: delim_q    <= cfg_data_i;
          default: ;
        endcase
      end
      count_q <= count_d;
      ne_q    <= ne_d;
      open_q  <= open_d;
      if (out_free) out_valid_q <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAP_SIZE + 1)))
    else $error("position counter out of range");

  a_closed_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (count_q == CNT_W'(1)) && ne_q)
    else $error("closed line keeps stale position state");

  a_newline_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == CMD_DATA && data_byte == NEWLINE) |=>
      (m_axis_tvalid && m_axis_tdata == NEWLINE && m_axis_tuser == KIND_BYTE))
    else $error("newline did not reach the output");

  a_mark_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == CMD_MARK && !range_bad) |=> (map_busy && !s_axis_tready))
    else $error("good range did not start the map update");

endmodule

// File: sv/lcc_map.sv
module lcc_map import lcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  map_req_t         map_req_i,
  input  logic [CNT_W-1:0] look_idx_i,
  output map_look_t        look_o,
  output logic             busy_o
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  valid_q;

  map_state_e state_q, state_d;

  logic [ROW_IDX_W-1:0] mark_row_q, last_row_q;
  logic [CNT_W-1:0]     first_q, last_q;
  logic [CNT_W-1:0]     look_idx_q;

  logic [ROW_W-1:0]     rd_a_q, rd_b_q;
  logic [ROW_IDX_W-1:0] addr_a, addr_b;
  logic [ROW_W-1:0]     mask, wr_data;
  logic                 rd_mark, we;

  logic [CNT_W-1:0]     look_nxt_in, look_nxt_q;
  logic [ROW_IDX_W-1:0] row_a, row_b;
  logic [BIT_W-1:0]     bit_a, bit_b;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      MAP_IDLE: begin
        if (map_req_i.mark) state_d = MAP_READ;
      end
      MAP_READ: begin
        state_d = MAP_WRITE;
      end
      MAP_WRITE: begin
        if (mark_row_q == last_row_q) state_d = MAP_REFRESH;
        else state_d = MAP_READ;
      end
      MAP_REFRESH: begin
        state_d = MAP_IDLE;
      end
      default: state_d = MAP_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_mark = 1'b0;
    we      = 1'b0;
    busy_o  = 1'b1;
    case (state_q)
      MAP_IDLE:    busy_o  = 1'b0;
      MAP_READ:    rd_mark = 1'b1;
      MAP_WRITE:   we      = 1'b1;
      MAP_REFRESH: busy_o  = 1'b1;
      default:     busy_o  = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= MAP_IDLE;
      valid_q    <= '0;
      look_idx_q <= '0;
      mark_row_q <= '0;
      last_row_q <= '0;
      first_q    <= '0;
      last_q     <= '0;
    end else begin
      state_q    <= state_d;
      look_idx_q <= look_idx_i;
      if (map_req_i.clear) begin
        valid_q <= '0;
      end
      if (map_req_i.mark && state_q == MAP_IDLE) begin
        mark_row_q <= row_of(map_req_i.first_idx);
        last_row_q <= row_of(map_req_i.last_idx);
        first_q    <= map_req_i.first_idx;
        last_q     <= map_req_i.last_idx;
      end
      if (we) begin
        valid_q[mark_row_q] <= 1'b1;
        if (mark_row_q != last_row_q) mark_row_q <= mark_row_q + 1'b1;
      end
    end
  end

  // positions of this row that fall inside the range
  always_comb begin
    logic [CNT_W:0] pos;
    for (int j = 0; j < ROW_W; j++) begin
      pos     = ((CNT_W+1)'(mark_row_q) << BIT_W) | (CNT_W+1)'(j);
      mask[j] = (pos >= {1'b0, first_q}) && (pos <= {1'b0, last_q});
    end
  end

  // a row that was cleared reads as all unselected
  assign wr_data = (valid_q[mark_row_q] ? rd_a_q : '0) | mask;

  assign look_nxt_in = look_idx_i + 1'b1;
  assign addr_a      = rd_mark ? mark_row_q : row_of(look_idx_i);
  assign addr_b      = row_of(look_nxt_in);

  always_ff @(posedge clk_i) begin
    if (we) mem[mark_row_q] <= wr_data;
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  assign look_nxt_q = look_idx_q + 1'b1;
  assign row_a      = row_of(look_idx_q);
  assign row_b      = row_of(look_nxt_q);
  assign bit_a      = look_idx_q[BIT_W-1:0];
  assign bit_b      = look_nxt_q[BIT_W-1:0];

  assign look_o.sel_cur  = (look_idx_q < CNT_W'(MAP_SIZE)) && valid_q[row_a] && rd_a_q[bit_a];
  assign look_o.sel_next = (look_nxt_q < CNT_W'(MAP_SIZE)) && valid_q[row_b] && rd_b_q[bit_b];

endmodule

// File: bench/line_field_char_cutter_test.sv
module line_field_char_cutter_test;
  import lcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_e             cmd;
    logic [RANGE_W-1:0] first_pos;
    logic [RANGE_W-1:0] last_pos;
    logic [BYTE_W-1:0]  data_b;
  } cut_req_t;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data_b;
  } cut_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]    m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  cut_req_t req_q[$];
  cut_res_t cut_result_q[$];
  int       err_cnt = 0;
  int       queued_cnt = 0;

  // cutter state as the block should hold it
  bit               sel_map [1:MAP_SIZE];
  logic [CNT_W-1:0] pos_cnt = 1;
  bit               none_out = 1'b1;
  bit               line_busy = 1'b0;
  bit               mode_chars = 1'b0;
  logic [BYTE_W-1:0] delim = DELIM_RESET;

  // driver and receiver bookkeeping
  int burst_left = 0;
  int gap_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int pat_left = 0;
  logic [7:0] stall_pat = 8'hFF;

  line_field_char_cutter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit pos_selected(input logic [CNT_W-1:0] p);
    if (p < 1 || p > MAP_SIZE) return 1'b0;
    return sel_map[p];
  endfunction

  function automatic void bump_pos();
    if (pos_cnt <= MAP_SIZE) pos_cnt++;
  endfunction

  function automatic void restart_line();
    pos_cnt = 1;
    none_out = 1'b1;
    line_busy = 1'b0;
  endfunction

  // returns 1 when the request yields a result, placed in res
  function automatic bit cut_step(input cut_req_t r, output cut_res_t res);
    bit closing;
    res.kind = KIND_BYTE;
    res.data_b = '0;
    cut_step = 1'b0;
    case (r.cmd)
      CMD_CLEAR: begin
        sel_map = '{default: 1'b0};
      end
      CMD_MARK: begin
        if (r.first_pos < 1 || r.last_pos > MAP_SIZE || r.first_pos > r.last_pos) begin
          res.kind = KIND_RANGE_BAD;
        end else begin
          for (int p = int'(r.first_pos); p <= int'(r.last_pos); p++) sel_map[p] = 1'b1;
          res.kind = KIND_RANGE_OK;
        end
        cut_step = 1'b1;
      end
      CMD_END: begin
        closing = line_busy && !mode_chars && (pos_selected(pos_cnt) || !none_out);
        restart_line();
        res.data_b = NEWLINE;
        cut_step = closing;
      end
      default: begin
        if (r.data_b == NEWLINE) begin
          restart_line();
          res.data_b = NEWLINE;
          cut_step = 1'b1;
        end else begin
          line_busy = 1'b1;
          res.data_b = r.data_b;
          if (mode_chars) begin
            cut_step = pos_selected(pos_cnt);
            bump_pos();
          end else begin
            if (pos_selected(pos_cnt)) none_out = 1'b0;
            if (r.data_b == delim) begin
              bump_pos();
              // separator only between two selected fields
              if (pos_selected(pos_cnt)) begin
                cut_step = !none_out;
                none_out = 1'b0;
              end
            end else begin
              cut_step = pos_selected(pos_cnt);
            end
          end
        end
      end
    endcase
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // driver: bursts of requests with random gaps
  always @(posedge clk_i) begin
    cut_req_t nxt;
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0 || req_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {nxt.data_b, nxt.last_pos, nxt.first_pos};
        s_axis_tuser <= nxt.cmd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus a long hold-off on demand
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 500;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left = 8;
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      end
      m_axis_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
      pat_left--;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    cut_req_t req;
    cut_res_t res;
    cut_res_t got;
    if (rst_n) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.cmd = cmd_e'(s_axis_tuser);
        req.first_pos = s_axis_tdata[11:0];
        req.last_pos = s_axis_tdata[23:12];
        req.data_b = s_axis_tdata[31:24];
        if (cut_step(req, res)) cut_result_q.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.data_b = m_axis_tdata;
        if (cut_result_q.size() == 0) begin
          flag_error($sformatf("unexpected result kind %0d byte %02h", got.kind, got.data_b));
        end else begin
          res = cut_result_q.pop_front();
          if (got.kind !== res.kind || got.data_b !== res.data_b) begin
            flag_error($sformatf("kind exp %0d got %0d, byte exp %02h got %02h",
                                 res.kind, got.kind, res.data_b, got.data_b));
          end
        end
      end
    end
  end

  task automatic queue_req(input cmd_e c, input logic [RANGE_W-1:0] f,
                           input logic [RANGE_W-1:0] l, input logic [BYTE_W-1:0] b);
    cut_req_t r;
    r.cmd = c;
    r.first_pos = f;
    r.last_pos = l;
    r.data_b = b;
    req_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic queue_cmd(input cmd_e c);
    queue_req(c, RANGE_W'($urandom), RANGE_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    queue_req(CMD_DATA, RANGE_W'($urandom), RANGE_W'($urandom), b);
  endtask

  task automatic queue_mark(input int f, input int l);
    queue_req(CMD_MARK, RANGE_W'(f), RANGE_W'(l), BYTE_W'($urandom));
  endtask

  task automatic add_range();
    int f;
    case ($urandom_range(0, 9))
      0: queue_mark(1, MAP_SIZE);
      1: begin
        f = $urandom_range(MAP_SIZE - 8, MAP_SIZE);
        queue_mark(f, $urandom_range(f, MAP_SIZE));
      end
      2: queue_mark(0, $urandom);
      3: queue_mark($urandom, $urandom);
      4: begin
        f = $urandom_range(2, 30);
        queue_mark(f, $urandom_range(1, f - 1));
      end
      default: begin
        f = $urandom_range(1, 20);
        queue_mark(f, f + $urandom_range(0, 6));
      end
    endcase
  endtask

  task automatic add_line(input int len, input bit terminate);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) queue_byte(delim);
      else if (r == 3) queue_byte(8'($urandom));
      else queue_byte(8'($urandom_range(97, 122)));
    end
    if (terminate) queue_byte(NEWLINE);
  endtask

  // idle means: nothing pending or offered, nothing expected, then room for
  // a mark still working through the map rows
  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || cut_result_q.size() != 0);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CUT_MODE) mode_chars = val[0];
    else delim = val;
    @(posedge clk_i);
  endtask

  initial begin
    int ph;
    int r;
    logic [BYTE_W-1:0] d;
    sel_map = '{default: 1'b0};
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, field mode with tab
    queue_mark(0, 5);
    queue_mark(1, 4095);
    queue_mark(10, 9);
    queue_mark(4095, 0);
    queue_mark(1, 1);
    queue_mark(3, 3);
    queue_mark(MAP_SIZE, MAP_SIZE);
    queue_byte("a");
    queue_byte(8'd9);
    queue_byte("b");
    queue_byte(8'd9);
    queue_byte(8'd9);           // empty selected third field
    queue_byte("c");
    queue_byte(8'd9);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(NEWLINE);
    queue_byte("x");
    queue_byte(8'd9);
    queue_byte("y");
    queue_cmd(CMD_END);         // closes the open line
    queue_cmd(CMD_END);         // no open line
    queue_cmd(CMD_CLEAR);
    queue_byte("z");
    queue_byte(NEWLINE);

    ph = 0;
    while (queued_cnt < 1050) begin
      wait_drained();
      case (ph % 6)
        0: d = NEWLINE;
        1: d = 8'hFF;
        2: d = 8'h00;
        3: d = ",";
        4: d = 8'd9;
        default: d = 8'($urandom);
      endcase
      write_reg(REG_CUT_MODE, (ph < 4) ? 8'(ph % 2) : 8'($urandom_range(0, 1)));
      write_reg(REG_DELIMITER, d);

      if (ph < 3 || $urandom_range(0, 2) != 0) queue_cmd(CMD_CLEAR);
      repeat ($urandom_range(1, 4)) add_range();

      if (ph == 2) begin
        // a line longer than the map in bytes, mostly delimiters, range at the map end
        queue_mark(MAP_SIZE - 6, MAP_SIZE);
        for (int i = 0; i < MAP_SIZE + 8; i++) begin
          if ($urandom_range(0, 7) != 0) queue_byte(delim);
          else queue_byte(8'($urandom_range(97, 122)));
        end
        queue_byte(NEWLINE);
      end else begin
        for (int n = 0; n < 25; ) begin
          r = $urandom_range(0, 39);
          if (r < 3) begin
            queue_cmd(CMD_END);
            n++;
          end else if (r < 5) begin
            add_range();
            n++;
          end else if (r == 5) begin
            queue_cmd(CMD_CLEAR);
            queue_mark($urandom_range(1, 6), $urandom_range(6, 24));
            n += 2;
          end else begin
            r = $urandom_range(0, 30);
            add_line(r, $urandom_range(0, 5) != 0);
            n += r + 1;
          end
        end
      end

      // long receiver hold-off while the queue is full
      if (ph == 1) hold_asks++;
      ph++;
    end

    wait_drained();
    if (err_cnt == 0 && cut_result_q.size() == 0) begin
      $display("line_field_char_cutter regression: pass");
    end else begin
      $display("line_field_char_cutter regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("line_field_char_cutter regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
sv/lcc_pkg.sv
sv/lcc_map.sv
sv/line_field_char_cutter.sv
bench/line_field_char_cutter_test.sv
